[rtl/square_qam128_mapper_demapper_assert.svh]
// Assertion macros for the 128-QAM mapper/demapper.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef SQUARE_QAM128_MAPPER_DEMAPPER_ASSERT_SVH
`define SQUARE_QAM128_MAPPER_DEMAPPER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SQM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SQM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/sqm_pkg.sv]
// Shared constants, mode codes and controller/datapath interface types
// for the 128-QAM mapper/demapper. No dependencies.
package sqm_pkg;

  localparam int TABLE_POINTS     = 32;
  localparam int IDX_W            = 5;
  localparam int SYM_W            = 7;
  localparam int QUAD_W           = SYM_W - IDX_W;
  localparam int SAMPLE_WIDTH_DEF = 16;

  typedef logic [1:0] mode_t;

  localparam mode_t MODE_LOAD  = 2'd0;
  localparam mode_t MODE_MOD   = 2'd1;
  localparam mode_t MODE_DEMOD = 2'd2;

  typedef struct packed {
    logic accept;
    logic scan;
    logic rd_sel;
    logic emit;
  } sqm_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic search_done;
    logic out_free;
  } sqm_stat_t;

endpackage

[rtl/sqm_ctrl.sv]
// Controller FSM for the 128-QAM mapper/demapper: sequences table scan,
// final table read and result transfer. Depends on sqm_pkg.
module sqm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  sqm_pkg::mode_t    mode,
  input  sqm_pkg::sqm_stat_t stat,
  output logic              in_ready,
  output sqm_pkg::sqm_cmd_t cmd
);
  import sqm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_WAIT = 5'b00100,
    ST_RD   = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t state, state_next;

  assign in_ready   = (state == ST_IDLE) && !rst;
  assign cmd.accept = in_valid && in_ready;
  assign cmd.scan   = (state == ST_SCAN);
  assign cmd.rd_sel = (state == ST_RD);
  assign cmd.emit   = (state == ST_OUT) && stat.out_free;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (cmd.accept) begin
          if (mode == MODE_MOD) begin
            state_next = ST_RD;
          end else if (mode == MODE_DEMOD) begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.scan_last) begin
          state_next = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (stat.search_done) begin
          state_next = ST_RD;
        end
      end
      ST_RD: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/sqm_dp.sv]
// Datapath for the 128-QAM mapper/demapper: point table memory, quadrant
// fold, pipelined distance search and output register. Depends on sqm_pkg.
module sqm_dp #(
  parameter int SAMPLE_WIDTH = sqm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sqm_pkg::sqm_cmd_t                 cmd,
  output sqm_pkg::sqm_stat_t                stat,
  input  sqm_pkg::mode_t                    mode,
  input  logic [sqm_pkg::SYM_W-1:0]         symbol_in,
  input  logic [sqm_pkg::IDX_W-1:0]         entry_index,
  input  logic signed [SAMPLE_WIDTH-1:0]    entry_real,
  input  logic signed [SAMPLE_WIDTH-1:0]    entry_imag,
  input  logic signed [SAMPLE_WIDTH-1:0]    rx_real,
  input  logic signed [SAMPLE_WIDTH-1:0]    rx_imag,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [sqm_pkg::SYM_W-1:0]         symbol_out,
  output logic signed [SAMPLE_WIDTH-1:0]    point_real,
  output logic signed [SAMPLE_WIDTH-1:0]    point_imag
);
  import sqm_pkg::*;

  localparam int SW = SAMPLE_WIDTH;
  localparam int DW = 2 * SW + 1;
  localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_POINTS - 1);

  function automatic logic signed [SW-1:0] sat_neg(input logic signed [SW-1:0] x);
    return (x == SMIN) ? SMAX : -x;
  endfunction

  logic [2*SW-1:0]          tbl [TABLE_POINTS];
  logic [2*SW-1:0]          rd_data;
  logic [IDX_W-1:0]         rd_addr;
  logic                     rd_en;
  logic                     rd_vld;
  logic [IDX_W-1:0]         rd_idx;
  logic [IDX_W-1:0]         scan_cnt;
  logic [IDX_W-1:0]         sel_idx;
  logic [QUAD_W-1:0]        quad;
  logic signed [SW-1:0]     fold_re, fold_im;
  logic signed [SW-1:0]     tr, ti, mr, mi;
  logic signed [SW:0]       dr, di;
  logic signed [2*SW+1:0]   pr, pi;
  logic [2*SW-1:0]          sq_re, sq_im;
  logic                     sq_vld;
  logic [IDX_W-1:0]         sq_idx;
  logic [DW-1:0]            cur_dist, best;

  // table memory: one write port (load), one registered read port
  assign rd_en   = cmd.scan || cmd.rd_sel;
  assign rd_addr = cmd.scan ? scan_cnt : sel_idx;

  always_ff @(posedge clk) begin
    if (cmd.accept && mode == MODE_LOAD) begin
      tbl[entry_index] <= {entry_real, entry_imag};
    end
    if (rd_en) begin
      rd_data <= tbl[rd_addr];
    end
  end

  assign tr = $signed(rd_data[2*SW-1:SW]);
  assign ti = $signed(rd_data[SW-1:0]);

  // distance pipeline
  assign dr       = $signed({fold_re[SW-1], fold_re}) - $signed({tr[SW-1], tr});
  assign di       = $signed({fold_im[SW-1], fold_im}) - $signed({ti[SW-1], ti});
  assign pr       = dr * dr;
  assign pi       = di * di;
  assign cur_dist = {1'b0, sq_re} + {1'b0, sq_im};

  // item capture, scan counter, search
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      scan_cnt <= '0;
      if (mode == MODE_MOD) begin
        sel_idx <= symbol_in[IDX_W-1:0];
        quad    <= symbol_in[SYM_W-1:IDX_W];
      end else if (mode == MODE_DEMOD) begin
        quad    <= {rx_real[SW-1], rx_imag[SW-1]};
        fold_re <= rx_real[SW-1] ? sat_neg(rx_real) : rx_real;
        fold_im <= rx_imag[SW-1] ? sat_neg(rx_imag) : rx_imag;
      end
    end else if (cmd.scan) begin
      scan_cnt <= scan_cnt + 1'b1;
    end
    rd_idx <= scan_cnt;
    sq_re  <= pr[2*SW-1:0];
    sq_im  <= pi[2*SW-1:0];
    sq_idx <= rd_idx;
    if (sq_vld && (sq_idx == '0 || cur_dist < best)) begin
      best    <= cur_dist;
      sel_idx <= sq_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
      sq_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.scan;
      sq_vld <= rd_vld;
    end
  end

  // result register
  assign mr = quad[1] ? sat_neg(tr) : tr;
  assign mi = quad[0] ? sat_neg(ti) : ti;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      symbol_out <= {quad, sel_idx};
      point_real <= mr;
      point_imag <= mi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.scan_last   = cmd.scan && (scan_cnt == LAST_IDX);
  assign stat.search_done = sq_vld && (sq_idx == LAST_IDX);
  assign stat.out_free    = !out_valid || out_ready;

endmodule

[rtl/square_qam128_mapper_demapper.sv]
// Top level of the square 128-QAM mapper and hard-decision demapper.
// Depends on sqm_pkg, sqm_ctrl, sqm_dp and the assertion macro header.
//
// One item at a time; no input is taken while rst is high. A load (mode 0)
// or an unused mode-3 item gives no result and leaves the input ready. A
// modulate item shows its result after one table read, then the output
// register. A demodulate item first reads the table memory once per cycle
// for all 32 points; the distance pipeline registers the squared terms, then
// the best distance; the chosen point is then read again and registered.
// The next item can be taken once the result is registered. A result
// waiting at the output does not hold off the next item; a second finished
// result waits inside and holds the input until the first is taken. The
// table holds nothing until loaded; reading an unloaded point gives
// unspecified values.
module square_qam128_mapper_demapper #(
  parameter int SAMPLE_WIDTH = sqm_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sqm_pkg::mode_t                 mode,
  input  logic [sqm_pkg::SYM_W-1:0]      symbol_in,
  input  logic [sqm_pkg::IDX_W-1:0]      entry_index,
  input  logic signed [SAMPLE_WIDTH-1:0] entry_real,
  input  logic signed [SAMPLE_WIDTH-1:0] entry_imag,
  input  logic signed [SAMPLE_WIDTH-1:0] rx_real,
  input  logic signed [SAMPLE_WIDTH-1:0] rx_imag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [sqm_pkg::SYM_W-1:0]      symbol_out,
  output logic signed [SAMPLE_WIDTH-1:0] point_real,
  output logic signed [SAMPLE_WIDTH-1:0] point_imag
);
  import sqm_pkg::*;

  sqm_cmd_t  cmd;
  sqm_stat_t stat;
  logic      work_start;

  sqm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .mode     (mode),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  sqm_dp #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .mode        (mode),
    .symbol_in   (symbol_in),
    .entry_index (entry_index),
    .entry_real  (entry_real),
    .entry_imag  (entry_imag),
    .rx_real     (rx_real),
    .rx_imag     (rx_imag),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .symbol_out  (symbol_out),
    .point_real  (point_real),
    .point_imag  (point_imag)
  );

  assign work_start = cmd.accept && (mode == MODE_MOD || mode == MODE_DEMOD);

`include "square_qam128_mapper_demapper_assert.svh"

  `SQM_ASSERT_NEXT(a_busy_after_item, work_start, !in_ready, "input taken while busy")
  `SQM_ASSERT_NEXT(a_done_to_read, stat.search_done, cmd.rd_sel, "no point read after search")
  `SQM_ASSERT_NEXT(a_done_once, stat.search_done, !stat.search_done, "search end seen twice")
  `SQM_ASSERT_NEXT(a_emit_shows, cmd.emit, out_valid, "result not shown after emit")

endmodule
